>>> design/chtlp_pkg.sv
// Shared types and constants for the counting hash table.
`timescale 1ns / 1ps
package chtlp_pkg;
  localparam int KEY_W = 64;
  localparam int CNT_W = 32;
  localparam int REQ_W = 2;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [REQ_W-1:0] {
    REQ_INC   = 2'd0,
    REQ_DEC   = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PRB_RD,
    ST_PRB_CHK,
    ST_SH_RD,
    ST_SH_CHK,
    ST_OUT
  } state_t;
endpackage

>>> design/chtlp_if.sv
// Valid/ready channel interface carrying one payload.
`timescale 1ns / 1ps
interface chtlp_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/counting_hash_table_linear_probe_top.sv
// Top level: sequencer driving the slot store for the counting hash table.
// Channels: req (req_type, key) in, rsp (key_count, status) out, valid/ready.
// One request at a time; req.ready is high only when idle and the result
// register is free or being taken in the same cycle.
// Probing reads one slot per step (registered read, then compare); rsp.valid
// is registered from ST_OUT after the last compare, and the next request can
// transfer in the same cycle as that result. A decrement to zero adds a
// backward shift step per slot examined, up to and including the empty slot
// that ends the cluster. Clear sweeps every slot, then gives a result.
// Reset clears the table by the same sweep, with req.ready low meanwhile and
// no result. Keys need no clearing.
// If the receiver stalls, the result is held in rsp; the next request is
// not taken until that result transfers.
// Exactly one result per request, in request order.
`timescale 1ns / 1ps
module counting_hash_table_linear_probe_top
  import chtlp_pkg::*;
#(
  parameter int LOG_SLOTS = 10
) (
  input logic clk,
  input logic rst,
  chtlp_if.sink   req,
  chtlp_if.source rsp
);
  localparam int N = 2**LOG_SLOTS;
  typedef logic [LOG_SLOTS-1:0] idx_t;
  localparam idx_t MASK_ONE = idx_t'(1);

  state_t state, state_next;
  req_t   op;
  logic [KEY_W-1:0] key_r;
  idx_t   pos, hole;
  logic [LOG_SLOTS:0] steps;
  logic [CNT_W-1:0] res;
  logic   stat;
  logic   ovalid;
  logic   boot;
  logic   clr_old;
  idx_t   clr_addr;

  idx_t raddr, waddr;
  logic [KEY_W-1:0] rkey, wkey;
  logic [CNT_W-1:0] rcnt, wcnt;
  logic kwe, cwe;

  chtlp_mem #(.LOG_SLOTS(LOG_SLOTS)) u_mem (
    .clk, .raddr, .rkey, .rcnt, .kwe, .cwe, .waddr, .wkey, .wcnt
  );

  logic accept, empty, hit, done_steps, move, shift_mv, sh_last;
  idx_t dist_home, dist_hole;
  assign accept = req.valid && req.ready;
  assign empty = (rcnt == '0);
  assign hit = !empty && (rkey == key_r);
  assign done_steps = (steps == (LOG_SLOTS+1)'(N));
  assign sh_last = (steps == (LOG_SLOTS+1)'(N-1));
  assign dist_home = pos - rkey[LOG_SLOTS-1:0];
  assign dist_hole = pos - hole;
  assign move = dist_home >= dist_hole;
  assign shift_mv = !empty && move;
  assign req.ready = (state == ST_IDLE) && (!ovalid || rsp.ready);
  assign rsp.valid = ovalid;
  assign rsp.data = {res, stat};
  assign raddr = pos;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) begin
        state_next = (req_t'(req.data[KEY_W+REQ_W-1:KEY_W]) == REQ_CLEAR) ?
                     ST_CLEAR : ST_PRB_RD;
      end
      ST_CLEAR: if (pos == idx_t'(N-1)) state_next = boot ? ST_IDLE : ST_OUT;
      ST_PRB_RD: state_next = ST_PRB_CHK;
      ST_PRB_CHK: begin
        if (hit && op == REQ_DEC && rcnt == 32'd1) state_next = ST_SH_RD;
        else if (hit || empty || done_steps) state_next = ST_OUT;
        else state_next = ST_PRB_RD;
      end
      ST_SH_RD: state_next = ST_SH_CHK;
      ST_SH_CHK: state_next = (empty || sh_last) ? ST_OUT : ST_SH_RD;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    kwe = 1'b0;
    cwe = 1'b0;
    waddr = pos;
    wkey = key_r;
    wcnt = '0;
    unique case (state)
      ST_CLEAR: cwe = 1'b1;
      ST_PRB_CHK: begin
        if (op == REQ_INC) begin
          if (hit) begin
            cwe = 1'b1;
            wcnt = (rcnt == COUNT_MAX) ? rcnt : rcnt + 32'd1;
          end else if (empty) begin
            kwe = 1'b1;
            cwe = 1'b1;
            wcnt = 32'd1;
          end
        end else if (op == REQ_DEC && hit) begin
          cwe = 1'b1;
          wcnt = rcnt - 32'd1;
        end
      end
      ST_SH_CHK: if (shift_mv) begin
        kwe = 1'b1;
        cwe = 1'b1;
        waddr = hole;
        wkey = rkey;
        wcnt = rcnt;
      end
      ST_SH_RD, ST_OUT: if (clr_old) begin
        cwe = 1'b1;
        waddr = clr_addr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      pos <= '0;
      ovalid <= 1'b0;
      clr_old <= 1'b0;
      boot <= 1'b1;
    end else begin
      state <= state_next;
      ovalid <= (state == ST_OUT) || (ovalid && !rsp.ready);
      clr_old <= (state == ST_SH_CHK) && shift_mv;
      unique case (state)
        ST_IDLE: if (accept) begin
          op <= req_t'(req.data[KEY_W+REQ_W-1:KEY_W]);
          key_r <= req.data[KEY_W-1:0];
          pos <= (req_t'(req.data[KEY_W+REQ_W-1:KEY_W]) == REQ_CLEAR) ?
                 '0 : req.data[LOG_SLOTS-1:0];
          steps <= '0;
          res <= '0;
          stat <= 1'b0;
        end
        ST_CLEAR: begin
          pos <= pos + MASK_ONE;
          if (pos == idx_t'(N-1)) boot <= 1'b0;
        end
        ST_PRB_RD: steps <= steps + 1'b1;
        ST_PRB_CHK: begin
          if (hit) begin
            unique case (op)
              REQ_INC: res <= (rcnt == COUNT_MAX) ? rcnt : rcnt + 32'd1;
              REQ_DEC: res <= rcnt - 32'd1;
              default: res <= rcnt;
            endcase
            hole <= pos;
            pos <= pos + MASK_ONE;
            steps <= '0;
          end else if (empty) begin
            if (op == REQ_INC) res <= 32'd1;
          end else if (done_steps) begin
            if (op == REQ_INC) stat <= 1'b1;
          end else begin
            pos <= pos + MASK_ONE;
          end
        end
        ST_SH_RD: steps <= steps + 1'b1;
        ST_SH_CHK: begin
          if (shift_mv) begin
            hole <= pos;
            clr_addr <= pos;
          end
          pos <= pos + MASK_ONE;
        end
        default: ;
      endcase
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data));
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> state == ST_IDLE);
  a_valid_idle: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> state == ST_IDLE);
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !kwe && !cwe);
endmodule

>>> design/chtlp_mem.sv
// Slot store: key and count arrays with one registered read port each.
`timescale 1ns / 1ps
module chtlp_mem
  import chtlp_pkg::*;
#(
  parameter int LOG_SLOTS = 10
) (
  input  logic                 clk,
  input  logic [LOG_SLOTS-1:0] raddr,
  output logic [KEY_W-1:0]     rkey,
  output logic [CNT_W-1:0]     rcnt,
  input  logic                 kwe,
  input  logic                 cwe,
  input  logic [LOG_SLOTS-1:0] waddr,
  input  logic [KEY_W-1:0]     wkey,
  input  logic [CNT_W-1:0]     wcnt
);
  logic [KEY_W-1:0] keys [2**LOG_SLOTS];
  logic [CNT_W-1:0] cnts [2**LOG_SLOTS];

  always_ff @(posedge clk) begin
    if (kwe) keys[waddr] <= wkey;
    if (cwe) cnts[waddr] <= wcnt;
    rkey <= keys[raddr];
    rcnt <= cnts[raddr];
  end
endmodule

>>> verif/hash_count_checker.sv
// Checker: predicts each key count and status and compares them with the responses.
`timescale 1ns / 1ps
module hash_count_checker
  import chtlp_pkg::*;
#(
  parameter int LOG_SLOTS = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_fire,
  input  req_t             req_type,
  input  logic [KEY_W-1:0] key,
  input  logic             rsp_fire,
  input  logic [CNT_W-1:0] key_count,
  input  logic             status,
  output int               errors,
  output int               pending
);
  localparam int NSLOTS = 1 << LOG_SLOTS;
  localparam int MASK = NSLOTS - 1;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             full;
  } count_result_t;

  logic [KEY_W-1:0] slot_key [NSLOTS];
  logic [CNT_W-1:0] slot_cnt [NSLOTS];
  count_result_t    expected_counts[$];

  function automatic int home_slot(logic [KEY_W-1:0] k);
    return int'(k[LOG_SLOTS-1:0]);
  endfunction

  task automatic close_gap(int pos);
    int hole;
    int i;
    int dist_home;
    int dist_hole;
    hole = pos;
    i = (pos + 1) & MASK;
    for (int n = 1; n < NSLOTS; n++) begin
      if (slot_cnt[i] == '0) break;
      dist_home = (i - home_slot(slot_key[i])) & MASK;
      dist_hole = (i - hole) & MASK;
      if (dist_home >= dist_hole) begin
        slot_key[hole] = slot_key[i];
        slot_cnt[hole] = slot_cnt[i];
        slot_cnt[i] = '0;
        hole = i;
      end
      i = (i + 1) & MASK;
    end
  endtask

  task automatic apply_request(req_t op, logic [KEY_W-1:0] k, output count_result_t res);
    int  i;
    int  where;
    bit  found;
    bit  empty_seen;
    found = 0;
    empty_seen = 0;
    where = 0;
    res = '0;
    i = home_slot(k);
    if (op != REQ_CLEAR) begin
      for (int n = 0; n < NSLOTS; n++) begin
        if (slot_cnt[i] == '0) begin
          where = i;
          empty_seen = 1;
          break;
        end
        if (slot_key[i] == k) begin
          where = i;
          found = 1;
          break;
        end
        i = (i + 1) & MASK;
      end
    end
    case (op)
      REQ_INC: begin
        if (found) begin
          if (slot_cnt[where] != COUNT_MAX) slot_cnt[where] = slot_cnt[where] + 1;
          res.count = slot_cnt[where];
        end else if (empty_seen) begin
          slot_key[where] = k;
          slot_cnt[where] = 1;
          res.count = 1;
        end else begin
          res.full = 1'b1;
        end
      end
      REQ_DEC: begin
        if (found) begin
          slot_cnt[where] = slot_cnt[where] - 1;
          res.count = slot_cnt[where];
          if (res.count == '0) close_gap(where);
        end
      end
      REQ_QUERY: begin
        if (found) res.count = slot_cnt[where];
      end
      default: begin
        for (int s = 0; s < NSLOTS; s++) slot_cnt[s] = '0;
      end
    endcase
  endtask

  assign pending = expected_counts.size();

  always @(posedge clk) begin
    count_result_t res;
    count_result_t want;
    if (rst) begin
      for (int s = 0; s < NSLOTS; s++) slot_cnt[s] = '0;
      expected_counts.delete();
      errors = 0;
    end else begin
      if (req_fire) begin
        apply_request(req_type, key, res);
        expected_counts.push_back(res);
      end
      if (rsp_fire) begin
        if (expected_counts.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("unexpected response: count %0d status %0d", key_count, status);
        end else begin
          want = expected_counts.pop_front();
          if (want.count !== key_count || want.full !== status) begin
            errors = errors + 1;
            if (errors <= 10)
              $display("mismatch: expected count %0d status %0d, got count %0d status %0d",
                       want.count, want.full, key_count, status);
          end
        end
      end
    end
  end
endmodule

>>> verif/tb_top.sv
// Testbench top: drives requests and response stalls, and reports the verdict.
`timescale 1ns / 1ps
module tb_top;
  import chtlp_pkg::*;

  localparam int LOG_SLOTS = 10;
  localparam int NSLOTS = 1 << LOG_SLOTS;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    req_t             req_type;
    logic [KEY_W-1:0] key;
  } req_pay_t;

  typedef struct packed {
    logic [CNT_W-1:0] key_count;
    logic             status;
  } rsp_pay_t;

  logic clk;
  logic rst;
  logic req_fire;
  logic rsp_fire;
  logic req_took;
  int   errors;
  int   pending;
  int   quiet_cycles;
  int   stall_left;
  bit   gaps_on;
  logic [KEY_W-1:0] hi_pool [8];

  chtlp_if #(.payload_t(req_pay_t)) req_ch (clk);
  chtlp_if #(.payload_t(rsp_pay_t)) rsp_ch (clk);

  counting_hash_table_linear_probe_top #(.LOG_SLOTS(LOG_SLOTS)) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  assign req_fire = req_ch.valid & req_ch.ready;
  assign rsp_fire = rsp_ch.valid & rsp_ch.ready;

  hash_count_checker #(.LOG_SLOTS(LOG_SLOTS)) u_checker (
    .clk(clk),
    .rst(rst),
    .req_fire(req_fire),
    .req_type(req_ch.data.req_type),
    .key(req_ch.data.key),
    .rsp_fire(rsp_fire),
    .key_count(rsp_ch.data.key_count),
    .status(rsp_ch.data.status),
    .errors(errors),
    .pending(pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) req_took <= req_fire;

  always @(posedge clk) begin
    if (rst || req_fire || rsp_fire) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      rsp_ch.ready = 1'b0;
      stall_left = stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 99) < 20) begin
      rsp_ch.ready = 1'b0;
      stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 3);
    end else begin
      rsp_ch.ready = 1'b1;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KEY_W-1:0] pool_key();
    logic [KEY_W-1:0] k;
    k = hi_pool[$urandom_range(0, 7)];
    k[LOG_SLOTS-1:0] = LOG_SLOTS'((NSLOTS - 6 + $urandom_range(0, 11)) % NSLOTS);
    return k;
  endfunction

  task automatic send(req_t op, logic [KEY_W-1:0] k);
    int g;
    req_ch.valid = 1'b1;
    req_ch.data.req_type = op;
    req_ch.data.key = k;
    do @(negedge clk); while (!req_took);
    g = gap_len();
    if (g > 0) begin
      req_ch.valid = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic random_ops(int n, int clear_pct);
    int r;
    for (int j = 0; j < n; j++) begin
      if (j % 150 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < clear_pct) send(REQ_CLEAR, rand_key());
      else if (r < 48) send(REQ_INC, ($urandom_range(0, 9) == 0) ? rand_key() : pool_key());
      else if (r < 78) send(REQ_DEC, ($urandom_range(0, 9) == 0) ? rand_key() : pool_key());
      else send(REQ_QUERY, ($urandom_range(0, 9) == 0) ? rand_key() : pool_key());
    end
  endtask

  initial begin
    logic [KEY_W-1:0] a;
    logic [KEY_W-1:0] b;
    logic [KEY_W-1:0] c;
    logic [KEY_W-1:0] fill_hi;
    rst = 1'b1;
    gaps_on = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    for (int p = 0; p < 8; p++) hi_pool[p] = rand_key();
    repeat (6) @(negedge clk);
    rst = 1'b0;

    a = '0;
    b = '1;
    c = {1'b1, {(KEY_W-1){1'b0}}};
    send(REQ_INC, a);
    send(REQ_INC, a);
    send(REQ_QUERY, a);
    send(REQ_DEC, a);
    send(REQ_DEC, a);
    send(REQ_DEC, a);
    send(REQ_QUERY, a);
    send(REQ_INC, b);
    send(REQ_INC, b ^ 64'h400);
    send(REQ_INC, b ^ 64'h800);
    send(REQ_INC, c);
    send(REQ_INC, a);
    send(REQ_DEC, b);
    send(REQ_QUERY, b ^ 64'h800);
    send(REQ_QUERY, c);
    send(REQ_QUERY, a);
    send(REQ_DEC, c);
    send(REQ_DEC, b ^ 64'h400);
    send(REQ_QUERY, b ^ 64'h800);
    send(REQ_CLEAR, b);
    send(REQ_QUERY, a);
    send(REQ_QUERY, b ^ 64'h800);

    random_ops(520, 3);

    send(REQ_CLEAR, a);
    fill_hi = rand_key();
    gaps_on = 1'b0;
    for (int s = 0; s < NSLOTS; s++) begin
      fill_hi[LOG_SLOTS-1:0] = LOG_SLOTS'((s * 7 + 3) % NSLOTS);
      send(REQ_INC, ($urandom_range(0, 1) == 0) ? fill_hi : (fill_hi ^ 64'h400));
    end
    gaps_on = 1'b1;
    send(REQ_INC, rand_key());
    send(REQ_INC, fill_hi);
    send(REQ_QUERY, rand_key());
    send(REQ_DEC, fill_hi);
    send(REQ_DEC, fill_hi);
    send(REQ_INC, rand_key());
    send(REQ_INC, rand_key());
    send(REQ_CLEAR, a);

    random_ops(60, 2);
    req_ch.valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end
endmodule

>>> sim.f
design/chtlp_pkg.sv
design/chtlp_if.sv
design/chtlp_mem.sv
design/counting_hash_table_linear_probe_top.sv
verif/hash_count_checker.sv
verif/tb_top.sv
